### src/vru_pkg.sv
// ----------------------------------------------------------------------------
// vru_pkg
// Shared types, constants and CORDIC tables for the vector rotation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vru_pkg;

  localparam int VRU_DATA_BITS  = 32;
  localparam int VRU_ANGLE_BITS = 16;
  localparam int LIMIT_W        = 16;
  localparam int VEC_W          = 64;   // internal component width
  localparam int CS_W           = 34;   // sine / cosine width, Q2.30 plus headroom
  localparam int TURN_W         = 32;   // internal angle width, 2^32 = one turn
  localparam int CORDIC_STEPS   = 30;

  localparam logic [LIMIT_W-1:0]  SMALL_LIMIT_RESET = LIMIT_W'(1);
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);
  localparam logic signed [CS_W-1:0] COEF_ONE    = CS_W'(1) <<< 30;

  localparam logic [TURN_W-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef enum logic [1:0] {
    REQ_EULER = 2'd0,
    REQ_ROT_Y = 2'd1,
    REQ_ROT_Z = 2'd2,
    REQ_ALIGN = 2'd3
  } req_t;

  // which two components a plane rotation acts on (u, v)
  typedef enum logic [1:0] {
    PAIR_XY = 2'd0,
    PAIR_YZ = 2'd1,
    PAIR_XZ = 2'd2
  } pair_t;

  typedef struct packed {
    pair_t                  pair;
    logic                   neg_s;
    logic signed [CS_W-1:0] c;
    logic signed [CS_W-1:0] s;
  } rot_cfg_t;

endpackage

`default_nettype wire

### src/vru_in_if.sv
// ----------------------------------------------------------------------------
// vru_in_if
// Request channel: vector, three angles, reference vector and request type.
// ----------------------------------------------------------------------------
`default_nettype none

interface vru_in_if import vru_pkg::*; #(
  parameter int DATA_BITS  = VRU_DATA_BITS,
  parameter int ANGLE_BITS = VRU_ANGLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [DATA_BITS-1:0]  in_x;
  logic signed [DATA_BITS-1:0]  in_y;
  logic signed [DATA_BITS-1:0]  in_z;
  logic [ANGLE_BITS-1:0]        angle_a;
  logic [ANGLE_BITS-1:0]        angle_b;
  logic [ANGLE_BITS-1:0]        angle_c;
  logic signed [DATA_BITS-1:0]  ref_x;
  logic signed [DATA_BITS-1:0]  ref_y;
  logic signed [DATA_BITS-1:0]  ref_z;

  modport source (
    output valid, req_type, in_x, in_y, in_z, angle_a, angle_b, angle_c,
    output ref_x, ref_y, ref_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, in_x, in_y, in_z, angle_a, angle_b, angle_c,
    input  ref_x, ref_y, ref_z,
    output ready
  );
endinterface

`default_nettype wire

### src/vru_out_if.sv
// ----------------------------------------------------------------------------
// vru_out_if
// Result channel: rotated, saturated vector and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vru_out_if import vru_pkg::*; #(
  parameter int DATA_BITS = VRU_DATA_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_BITS-1:0]  out_x;
  logic signed [DATA_BITS-1:0]  out_y;
  logic signed [DATA_BITS-1:0]  out_z;
  logic                         saturated;

  modport source (
    output valid, out_x, out_y, out_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, saturated,
    output ready
  );
endinterface

`default_nettype wire

### src/vru_cfg_if.sv
// ----------------------------------------------------------------------------
// vru_cfg_if
// Configuration write channel for the azimuth small limit.
// ----------------------------------------------------------------------------
`default_nettype none

interface vru_cfg_if import vru_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] small_limit;

  modport source (output valid, small_limit, input ready);
  modport sink   (input valid, small_limit, output ready);
endinterface

`default_nettype wire

### src/vru_cordic.sv
// ----------------------------------------------------------------------------
// vru_cordic
// Fully pipelined CORDIC, one step per stage; rotation or vectoring per request.
// ----------------------------------------------------------------------------
`default_nettype none

module vru_cordic import vru_pkg::*; #(
  parameter int XW = VEC_W,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_vec,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic [TURN_W-1:0]    in_z,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic [TURN_W-1:0]    out_z,
  output logic [SW-1:0]        out_side
);

  logic                 v_r    [CORDIC_STEPS+1];
  logic                 vec_r  [CORDIC_STEPS+1];
  logic signed [XW-1:0] x_r    [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_r    [CORDIC_STEPS+1];
  logic [TURN_W-1:0]    z_r    [CORDIC_STEPS+1];
  logic [SW-1:0]        side_r [CORDIC_STEPS+1];

  // entry stage: vectoring folds the left half plane onto the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r[0]  <= in_vec;
      side_r[0] <= in_side;
      if (in_vec && in_x[XW-1]) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= TURN_W'(1) << (TURN_W - 1);
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= in_z;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 rot_pos;

    assign dx      = y_r[k] >>> k;
    assign dy      = x_r[k] >>> k;
    assign rot_pos = vec_r[k] ? y_r[k][XW-1] : !z_r[k][TURN_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vec_r[k+1]  <= vec_r[k];
        side_r[k+1] <= side_r[k];
        if (rot_pos) begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - STEP_ANGLE[k];
        end else begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + STEP_ANGLE[k];
        end
      end
    end
  end

  assign out_valid = v_r[CORDIC_STEPS];
  assign out_x     = x_r[CORDIC_STEPS];
  assign out_y     = y_r[CORDIC_STEPS];
  assign out_z     = z_r[CORDIC_STEPS];
  assign out_side  = side_r[CORDIC_STEPS];

endmodule

`default_nettype wire

### src/vru_rot.sv
// ----------------------------------------------------------------------------
// vru_rot
// Five-stage plane rotation of one component pair: four rounded Q2.30
// products (ties away from zero), each split into two 32-bit multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module vru_rot import vru_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [VEC_W-1:0] in_y,
  input  logic signed [VEC_W-1:0] in_z,
  input  rot_cfg_t                in_cfg,
  input  logic [SW-1:0]           in_side,
  output logic                    out_valid,
  output logic signed [VEC_W-1:0] out_x,
  output logic signed [VEC_W-1:0] out_y,
  output logic signed [VEC_W-1:0] out_z,
  output logic [SW-1:0]           out_side
);

  localparam int NP    = 4;   // c*u, s*v, c*v, s*u
  localparam int NSTG  = 5;
  localparam logic [64:0] ROUND_HALF = 65'd1 << 29;
  localparam logic [61:0] DATA_CAP   = {62{1'b1}};
  localparam logic [CS_W-1:0] COEF_CAP = CS_W'(1) << 31;

  function automatic logic [31:0] coef_mag(logic signed [CS_W-1:0] c);
    logic [CS_W-1:0] m;
    m = c[CS_W-1] ? CS_W'(-c) : CS_W'(c);
    return (m > COEF_CAP) ? 32'h8000_0000 : m[31:0];
  endfunction

  function automatic logic [61:0] data_mag(logic signed [VEC_W-1:0] a);
    logic [VEC_W-1:0] m;
    m = a[VEC_W-1] ? VEC_W'(-a) : VEC_W'(a);
    return (m > VEC_W'(DATA_CAP)) ? DATA_CAP : m[61:0];
  endfunction

  logic                    v_r    [1:NSTG];
  logic signed [VEC_W-1:0] w_r    [1:NSTG];
  pair_t                   pair_r [1:NSTG];
  logic [SW-1:0]           side_r [1:NSTG];

  logic [31:0]             uc1_r [NP];
  logic [61:0]             ua1_r [NP];
  logic                    ng_r  [1:3][NP];
  logic [61:0]             hp2_r [NP];
  logic [63:0]             lp2_r [NP];
  logic [63:0]             q3_r  [NP];
  logic signed [VEC_W-1:0] p4_r  [NP];
  logic signed [VEC_W-1:0] nu5_r;
  logic signed [VEC_W-1:0] nv5_r;

  logic signed [VEC_W-1:0] u, v, w;
  logic signed [CS_W-1:0]  oc [NP];
  logic signed [VEC_W-1:0] oa [NP];
  logic                    of [NP];
  logic [64:0]             rnd [NP];

  always_comb begin
    case (in_cfg.pair)
      PAIR_YZ: begin u = in_y; v = in_z; w = in_x; end
      PAIR_XZ: begin u = in_x; v = in_z; w = in_y; end
      default: begin u = in_x; v = in_y; w = in_z; end
    endcase
    oc[0] = in_cfg.c; oa[0] = u; of[0] = 1'b0;
    oc[1] = in_cfg.s; oa[1] = v; of[1] = in_cfg.neg_s;
    oc[2] = in_cfg.c; oa[2] = v; of[2] = 1'b0;
    oc[3] = in_cfg.s; oa[3] = u; of[3] = in_cfg.neg_s;
    for (int j = 0; j < NP; j++) begin
      rnd[j] = {1'b0, lp2_r[j]} + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NSTG; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[1]    <= w;
      pair_r[1] <= in_cfg.pair;
      side_r[1] <= in_side;
      for (int k = 2; k <= NSTG; k++) begin
        w_r[k]    <= w_r[k-1];
        pair_r[k] <= pair_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      for (int j = 0; j < NP; j++) begin
        // stage 1: magnitudes and product sign
        uc1_r[j]   <= coef_mag(oc[j]);
        ua1_r[j]   <= data_mag(oa[j]);
        ng_r[1][j] <= oc[j][CS_W-1] ^ of[j] ^ oa[j][VEC_W-1];
        // stage 2: split multiply
        hp2_r[j]   <= ua1_r[j][61:32] * uc1_r[j];
        lp2_r[j]   <= ua1_r[j][31:0] * uc1_r[j];
        ng_r[2][j] <= ng_r[1][j];
        // stage 3: recombine with rounding
        q3_r[j]    <= {hp2_r[j], 2'b00} + 64'(rnd[j][64:30]);
        ng_r[3][j] <= ng_r[2][j];
        // stage 4: apply sign
        p4_r[j]    <= ng_r[3][j] ? -$signed(q3_r[j]) : $signed(q3_r[j]);
      end
      // stage 5: pair sums
      nu5_r <= p4_r[0] + p4_r[1];
      nv5_r <= p4_r[2] - p4_r[3];
    end
  end

  always_comb begin
    case (pair_r[NSTG])
      PAIR_YZ: begin out_x = w_r[NSTG]; out_y = nu5_r; out_z = nv5_r; end
      PAIR_XZ: begin out_x = nu5_r; out_y = w_r[NSTG]; out_z = nv5_r; end
      default: begin out_x = nu5_r; out_y = nv5_r; out_z = w_r[NSTG]; end
    endcase
  end

  assign out_valid = v_r[NSTG];
  assign out_side  = side_r[NSTG];

endmodule

`default_nettype wire

### src/vector_rotation_unit_top.sv
// ----------------------------------------------------------------------------
// vector_rotation_unit_top
// Pipelined 3-D fixed-point vector rotation: Euler, single-axis and
// align-to-reference requests, CORDIC sine/cosine, saturated output.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+---------------------------------------------
//  cfg_ch  | in  | valid / ready  | small_limit (16b, reset 1)
//  in_ch   | in  | valid / ready  | req_type, in_x/y/z, angle_a/b/c, ref_x/y/z
//  out_ch  | out | valid / ready  | out_x/y/z, saturated
//
//  The path from request accept to result valid runs through: input register,
//  31-stage vectoring CORDIC (reference azimuth), 5-stage gain correction,
//  31-stage vectoring CORDIC (polar angle), three parallel 31-stage sine/cosine
//  CORDICs, coefficient fold, three 5-stage plane rotations, output register.
//  One request is accepted per cycle; the long serial CORDIC chain sets depth.
//  Synchronous active-low reset clears all valid bits and sets small_limit to 1.
//  A stall on out_ch freezes the whole pipeline; in_ch.ready drops with it.
//
`default_nettype none

module vector_rotation_unit_top import vru_pkg::*; #(
  parameter int DATA_BITS  = VRU_DATA_BITS,
  parameter int ANGLE_BITS = VRU_ANGLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  vru_cfg_if.sink   cfg_ch,
  vru_in_if.sink    in_ch,
  vru_out_if.source out_ch
);

  localparam int SCALE_SH = 60 - DATA_BITS;      // vectoring guard shift
  localparam int ANG_SH   = TURN_W - ANGLE_BITS;  // widen to 32-bit turns
  localparam logic signed [VEC_W-1:0] DATA_MAX = (VEC_W'(1) <<< (DATA_BITS - 1)) - 1;
  localparam logic signed [VEC_W-1:0] DATA_MIN = -DATA_MAX - 1;

  typedef struct packed {
    req_t                    mode;
    logic signed [VEC_W-1:0] x, y, z;
    logic [TURN_W-1:0]       pa, pb, pc;
    logic signed [VEC_W-1:0] rz_s;
    logic                    zero_ref;
    logic                    below_lim;
  } a_side_t;

  typedef struct packed {
    a_side_t                 side;
    logic signed [VEC_W-1:0] rx_s, ry_s;
  } s0_t;

  typedef struct packed {
    req_t                    mode;
    logic signed [VEC_W-1:0] x, y, z;
    logic [TURN_W-1:0]       pa, pb, pc;
    logic signed [VEC_W-1:0] rz_s;
    logic                    zero_ref;
    logic [TURN_W-1:0]       azim;
  } b_side_t;

  typedef struct packed {
    req_t                    mode;
    logic signed [VEC_W-1:0] x, y, z;
    logic [TURN_W-1:0]       pa, pb, pc;
    logic                    zero_ref;
    logic [TURN_W-1:0]       azim;
  } c_side_t;

  typedef struct packed {
    req_t                    mode;
    logic signed [VEC_W-1:0] x, y, z;
    logic [1:0]              quad;
  } d_side_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x, y, z;
    rot_cfg_t                r1, r2, r3;
  } fold_t;

  typedef struct packed {
    rot_cfg_t r2;
    rot_cfg_t r3;
  } r23_t;

  // global advance: output register empty or being drained
  logic en;
  assign en = !out_ch.valid || out_ch.ready;

  // ---------------- configuration ----------------
  logic [LIMIT_W-1:0] small_limit_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_limit_r <= SMALL_LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      small_limit_r <= cfg_ch.small_limit;
    end
  end

  // ---------------- input register ----------------
  logic s0_v_r;
  s0_t  s0_r, s0_nxt;
  logic signed [VEC_W-1:0] rx, ry, rz;
  logic [VEC_W-1:0]        rx_mag, ry_mag;

  assign in_ch.ready = en;

  always_comb begin
    rx     = VEC_W'(in_ch.ref_x);
    ry     = VEC_W'(in_ch.ref_y);
    rz     = VEC_W'(in_ch.ref_z);
    rx_mag = rx[VEC_W-1] ? VEC_W'(-rx) : VEC_W'(rx);
    ry_mag = ry[VEC_W-1] ? VEC_W'(-ry) : VEC_W'(ry);
    s0_nxt.side.mode      = req_t'(in_ch.req_type);
    s0_nxt.side.x         = VEC_W'(in_ch.in_x);
    s0_nxt.side.y         = VEC_W'(in_ch.in_y);
    s0_nxt.side.z         = VEC_W'(in_ch.in_z);
    s0_nxt.side.pa        = TURN_W'(in_ch.angle_a) << ANG_SH;
    s0_nxt.side.pb        = TURN_W'(in_ch.angle_b) << ANG_SH;
    s0_nxt.side.pc        = TURN_W'(in_ch.angle_c) << ANG_SH;
    s0_nxt.side.rz_s      = rz <<< SCALE_SH;
    s0_nxt.side.zero_ref  = (rx == '0) && (ry == '0) && (rz == '0);
    s0_nxt.side.below_lim = (rx_mag < VEC_W'(small_limit_r)) &&
                            (ry_mag < VEC_W'(small_limit_r));
    s0_nxt.rx_s           = rx <<< SCALE_SH;
    s0_nxt.ry_s           = ry <<< SCALE_SH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  // ---------------- reference azimuth ----------------
  logic                    c1_v;
  logic signed [VEC_W-1:0] c1_x;
  logic [TURN_W-1:0]       c1_z;
  a_side_t                 c1_side;

  vru_cordic #(.XW(VEC_W), .SW($bits(a_side_t))) u_vec_azim (
    .clk, .rst_n, .en,
    .in_valid (s0_v_r),
    .in_vec   (1'b1),
    .in_x     (s0_r.rx_s),
    .in_y     (s0_r.ry_s),
    .in_z     ('0),
    .in_side  (s0_r.side),
    .out_valid(c1_v),
    .out_x    (c1_x),
    .out_y    (),
    .out_z    (c1_z),
    .out_side (c1_side)
  );

  // ---------------- gain correction: rho = K * |(rx, ry)| ----------------
  b_side_t  b_in, b_out;
  rot_cfg_t gain_cfg;
  logic     rho_v;
  logic signed [VEC_W-1:0] rho;

  always_comb begin
    b_in.mode     = c1_side.mode;
    b_in.x        = c1_side.x;
    b_in.y        = c1_side.y;
    b_in.z        = c1_side.z;
    b_in.pa       = c1_side.pa;
    b_in.pb       = c1_side.pb;
    b_in.pc       = c1_side.pc;
    b_in.rz_s     = c1_side.rz_s;
    b_in.zero_ref = c1_side.zero_ref;
    b_in.azim     = c1_side.below_lim ? '0 : c1_z;
    gain_cfg.pair  = PAIR_XY;
    gain_cfg.neg_s = 1'b0;
    gain_cfg.c     = CORDIC_GAIN;
    gain_cfg.s     = '0;
  end

  vru_rot #(.SW($bits(b_side_t))) u_rho (
    .clk, .rst_n, .en,
    .in_valid (c1_v),
    .in_x     (c1_x),
    .in_y     ('0),
    .in_z     ('0),
    .in_cfg   (gain_cfg),
    .in_side  (b_in),
    .out_valid(rho_v),
    .out_x    (rho),
    .out_y    (),
    .out_z    (),
    .out_side (b_out)
  );

  // ---------------- polar angle ----------------
  c_side_t           c2_in, c2_side;
  logic              c2_v;
  logic [TURN_W-1:0] c2_z;

  always_comb begin
    c2_in.mode     = b_out.mode;
    c2_in.x        = b_out.x;
    c2_in.y        = b_out.y;
    c2_in.z        = b_out.z;
    c2_in.pa       = b_out.pa;
    c2_in.pb       = b_out.pb;
    c2_in.pc       = b_out.pc;
    c2_in.zero_ref = b_out.zero_ref;
    c2_in.azim     = b_out.azim;
  end

  vru_cordic #(.XW(VEC_W), .SW($bits(c_side_t))) u_vec_polar (
    .clk, .rst_n, .en,
    .in_valid (rho_v),
    .in_vec   (1'b1),
    .in_x     (b_out.rz_s),
    .in_y     (rho),
    .in_z     ('0),
    .in_side  (c2_in),
    .out_valid(c2_v),
    .out_x    (),
    .out_y    (),
    .out_z    (c2_z),
    .out_side (c2_side)
  );

  // ---------------- angle selection and sine/cosine ----------------
  logic [TURN_W-1:0] polar, ang_a, ang_b, ang_c;
  d_side_t           d_in, d_out;

  always_comb begin
    polar = c2_side.zero_ref ? '0 : c2_z;
    unique case (c2_side.mode)
      REQ_EULER: begin ang_a = c2_side.pa; ang_b = c2_side.pb;   ang_c = c2_side.pc; end
      REQ_ROT_Y: begin ang_a = c2_side.pb; ang_b = '0;           ang_c = '0; end
      REQ_ROT_Z: begin ang_a = c2_side.pb; ang_b = '0;           ang_c = '0; end
      REQ_ALIGN: begin ang_a = polar;      ang_b = c2_side.azim; ang_c = '0; end
    endcase
    d_in.mode = c2_side.mode;
    d_in.x    = c2_side.x;
    d_in.y    = c2_side.y;
    d_in.z    = c2_side.z;
    d_in.quad = ang_a[TURN_W-1 -: 2];
  end

  logic                   sa_v;
  logic signed [CS_W-1:0] sa_x, sa_y, sb_x, sb_y, sc_x, sc_y;
  logic [1:0]             qb, qc;

  vru_cordic #(.XW(CS_W), .SW($bits(d_side_t))) u_sc_a (
    .clk, .rst_n, .en,
    .in_valid (c2_v),
    .in_vec   (1'b0),
    .in_x     (CORDIC_GAIN),
    .in_y     ('0),
    .in_z     ({2'b00, ang_a[TURN_W-3:0]}),
    .in_side  (d_in),
    .out_valid(sa_v),
    .out_x    (sa_x),
    .out_y    (sa_y),
    .out_z    (),
    .out_side (d_out)
  );

  vru_cordic #(.XW(CS_W), .SW(2)) u_sc_b (
    .clk, .rst_n, .en,
    .in_valid (c2_v),
    .in_vec   (1'b0),
    .in_x     (CORDIC_GAIN),
    .in_y     ('0),
    .in_z     ({2'b00, ang_b[TURN_W-3:0]}),
    .in_side  (ang_b[TURN_W-1 -: 2]),
    .out_valid(),
    .out_x    (sb_x),
    .out_y    (sb_y),
    .out_z    (),
    .out_side (qb)
  );

  vru_cordic #(.XW(CS_W), .SW(2)) u_sc_c (
    .clk, .rst_n, .en,
    .in_valid (c2_v),
    .in_vec   (1'b0),
    .in_x     (CORDIC_GAIN),
    .in_y     ('0),
    .in_z     ({2'b00, ang_c[TURN_W-3:0]}),
    .in_side  (ang_c[TURN_W-1 -: 2]),
    .out_valid(),
    .out_x    (sc_x),
    .out_y    (sc_y),
    .out_z    (),
    .out_side (qc)
  );

  // ---------------- quadrant fold, per-rotation setup ----------------
  function automatic rot_cfg_t make_cfg(logic [1:0] q, logic signed [CS_W-1:0] x,
                                        logic signed [CS_W-1:0] y, pair_t pair,
                                        logic neg_s);
    rot_cfg_t r;
    r.pair  = pair;
    r.neg_s = neg_s;
    unique case (q)
      2'd0: begin r.c = x;  r.s = y;  end
      2'd1: begin r.c = -y; r.s = x;  end
      2'd2: begin r.c = -x; r.s = -y; end
      2'd3: begin r.c = y;  r.s = -x; end
    endcase
    return r;
  endfunction

  rot_cfg_t ident_cfg;
  fold_t    f_r, f_nxt;
  logic     f_v_r;

  always_comb begin
    ident_cfg.pair  = PAIR_XY;
    ident_cfg.neg_s = 1'b0;
    ident_cfg.c     = COEF_ONE;  // exact pass-through
    ident_cfg.s     = '0;
    f_nxt.x = d_out.x;
    f_nxt.y = d_out.y;
    f_nxt.z = d_out.z;
    unique case (d_out.mode)
      REQ_EULER: begin
        f_nxt.r1 = make_cfg(d_out.quad, sa_x, sa_y, PAIR_XY, 1'b0);
        f_nxt.r2 = make_cfg(qb, sb_x, sb_y, PAIR_YZ, 1'b0);
        f_nxt.r3 = make_cfg(qc, sc_x, sc_y, PAIR_XY, 1'b0);
      end
      REQ_ROT_Y: begin
        f_nxt.r1 = make_cfg(d_out.quad, sa_x, sa_y, PAIR_XZ, 1'b0);
        f_nxt.r2 = ident_cfg;
        f_nxt.r3 = ident_cfg;
      end
      REQ_ROT_Z: begin
        f_nxt.r1 = make_cfg(d_out.quad, sa_x, sa_y, PAIR_XY, 1'b1);
        f_nxt.r2 = ident_cfg;
        f_nxt.r3 = ident_cfg;
      end
      REQ_ALIGN: begin
        f_nxt.r1 = make_cfg(d_out.quad, sa_x, sa_y, PAIR_XZ, 1'b0);
        f_nxt.r2 = make_cfg(qb, sb_x, sb_y, PAIR_XY, 1'b1);
        f_nxt.r3 = ident_cfg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_nxt;
    end
  end

  // ---------------- three plane rotations ----------------
  r23_t                    r23_in, r23_out;
  rot_cfg_t                r3_out;
  logic                    rt1_v, rt2_v, rt3_v;
  logic signed [VEC_W-1:0] a1_x, a1_y, a1_z, a2_x, a2_y, a2_z, a3_x, a3_y, a3_z;

  assign r23_in.r2 = f_r.r2;
  assign r23_in.r3 = f_r.r3;

  vru_rot #(.SW($bits(r23_t))) u_rot1 (
    .clk, .rst_n, .en,
    .in_valid (f_v_r),
    .in_x     (f_r.x),
    .in_y     (f_r.y),
    .in_z     (f_r.z),
    .in_cfg   (f_r.r1),
    .in_side  (r23_in),
    .out_valid(rt1_v),
    .out_x    (a1_x),
    .out_y    (a1_y),
    .out_z    (a1_z),
    .out_side (r23_out)
  );

  vru_rot #(.SW($bits(rot_cfg_t))) u_rot2 (
    .clk, .rst_n, .en,
    .in_valid (rt1_v),
    .in_x     (a1_x),
    .in_y     (a1_y),
    .in_z     (a1_z),
    .in_cfg   (r23_out.r2),
    .in_side  (r23_out.r3),
    .out_valid(rt2_v),
    .out_x    (a2_x),
    .out_y    (a2_y),
    .out_z    (a2_z),
    .out_side (r3_out)
  );

  vru_rot #(.SW(1)) u_rot3 (
    .clk, .rst_n, .en,
    .in_valid (rt2_v),
    .in_x     (a2_x),
    .in_y     (a2_y),
    .in_z     (a2_z),
    .in_cfg   (r3_out),
    .in_side  (1'b0),
    .out_valid(rt3_v),
    .out_x    (a3_x),
    .out_y    (a3_y),
    .out_z    (a3_z),
    .out_side ()
  );

  // ---------------- saturation and output register ----------------
  function automatic logic [DATA_BITS:0] clamp(logic signed [VEC_W-1:0] v);
    // {clamped flag, value}
    if (v > DATA_MAX) return {1'b1, DATA_MAX[DATA_BITS-1:0]};
    if (v < DATA_MIN) return {1'b1, DATA_MIN[DATA_BITS-1:0]};
    return {1'b0, v[DATA_BITS-1:0]};
  endfunction

  logic [DATA_BITS:0]   cx, cy, cz;
  logic                 out_valid_r, out_sat_r;
  logic [DATA_BITS-1:0] out_x_r, out_y_r, out_z_r;

  assign cx = clamp(a3_x);
  assign cy = clamp(a3_y);
  assign cz = clamp(a3_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rt3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= cx[DATA_BITS-1:0];
      out_y_r   <= cy[DATA_BITS-1:0];
      out_z_r   <= cz[DATA_BITS-1:0];
      out_sat_r <= cx[DATA_BITS] | cy[DATA_BITS] | cz[DATA_BITS];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.out_z     = out_z_r;
  assign out_ch.saturated = out_sat_r;

`ifndef SYNTH
  // a stalled pipeline must not drop or invent the entry request
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s0_v_r) && $stable(f_v_r))
    else $error("pipeline valid moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s0_v_r)
    else $error("valid bits not cleared by reset");

  // a clamped result must sit on a range limit in some component
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |->
      out_x_r == DATA_MAX[DATA_BITS-1:0] || out_x_r == DATA_MIN[DATA_BITS-1:0] ||
      out_y_r == DATA_MAX[DATA_BITS-1:0] || out_y_r == DATA_MIN[DATA_BITS-1:0] ||
      out_z_r == DATA_MAX[DATA_BITS-1:0] || out_z_r == DATA_MIN[DATA_BITS-1:0])
    else $error("saturated flag without clamped component");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vector_rotation_unit_top. A bit-exact predictor
// (CORDIC sine/cosine, vectoring CORDIC, rounded products, output clamp)
// builds the expected result of every accepted request; a monitor compares
// each result with the oldest expectation. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import vru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               sat;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  vru_cfg_if cfg_ch();
  vru_in_if  in_ch();
  vru_out_if out_ch();

  vector_rotation_unit_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor copy of the azimuth limit
  logic [15:0] limit_q = SMALL_LIMIT_RESET;
  rot_result_t rotated_q[$];
  int unsigned n_err = 0, n_sent = 0, n_seen = 0, n_sat = 0;
  int unsigned n_cycle = 0;
  bit calm = 1'b0;  // no idling on either side while set

  localparam longint unsigned TURN_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };
  localparam longint GAIN_K = 652032874;

  // rounded c*a/2^30, ties away from zero, operands clipped as in hardware
  function automatic longint fx_mul(longint c, longint a);
    bit neg;
    longint unsigned uc, ua, hi, lo, q;
    neg = (c < 0) != (a < 0);
    uc = (c < 0) ? -c : c;
    ua = (a < 0) ? -a : a;
    if (uc > (64'd1 << 31)) uc = 64'd1 << 31;
    if (ua > ((64'd1 << 62) - 1)) ua = (64'd1 << 62) - 1;
    hi = ua >> 32;
    lo = ua & 64'hFFFF_FFFF;
    q = ((hi * uc) << 2) + ((lo * uc + (64'd1 << 29)) >> 30);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void turn_sincos(logic [31:0] t, output longint cs,
                                      output longint sn);
    longint x, y, z, dx, dy;
    x = GAIN_K; y = 0; z = t[29:0];
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= TURN_STEP[i];
      end else begin
        x += dx; y -= dy; z += TURN_STEP[i];
      end
    end
    case (t[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic logic [31:0] vec_angle(longint x, longint y, output longint mag);
    logic [31:0] z;
    longint dx, dy;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += TURN_STEP[i][31:0];
      end else begin
        x -= dx; y += dy; z -= TURN_STEP[i][31:0];
      end
    end
    mag = fx_mul(GAIN_K, x);
    return z;
  endfunction

  function automatic void plane_rot(inout longint u, inout longint v,
                                    input longint c, input longint s);
    longint nu, nv;
    nu = fx_mul(c, u) + fx_mul(s, v);
    nv = fx_mul(c, v) - fx_mul(s, u);
    u = nu; v = nv;
  endfunction

  function automatic logic [31:0] clip32(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1; return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1; return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic rot_result_t rotate_vector(req_t op, logic signed [31:0] vx,
      logic signed [31:0] vy, logic signed [31:0] vz, logic [15:0] a, logic [15:0] b,
      logic [15:0] cc, logic signed [31:0] rx, logic signed [31:0] ry,
      logic signed [31:0] rz);
    longint x, y, z, c, s, rho, dummy, ax, ay;
    logic [31:0] azim, polar;
    rot_result_t r;
    x = vx; y = vy; z = vz;
    case (op)
      REQ_EULER: begin
        turn_sincos({a, 16'h0}, c, s);  plane_rot(x, y, c, s);
        turn_sincos({b, 16'h0}, c, s);  plane_rot(y, z, c, s);
        turn_sincos({cc, 16'h0}, c, s); plane_rot(x, y, c, s);
      end
      REQ_ROT_Y: begin
        turn_sincos({b, 16'h0}, c, s); plane_rot(x, z, c, s);
      end
      REQ_ROT_Z: begin
        turn_sincos({b, 16'h0}, c, s); plane_rot(x, y, c, -s);
      end
      default: begin
        azim = vec_angle(longint'(rx) <<< 28, longint'(ry) <<< 28, rho);
        polar = 0;
        if (rx != 0 || ry != 0 || rz != 0)
          polar = vec_angle(longint'(rz) <<< 28, rho, dummy);
        ax = (rx < 0) ? -longint'(rx) : rx;
        ay = (ry < 0) ? -longint'(ry) : ry;
        if (ax < limit_q && ay < limit_q) azim = 0;
        turn_sincos(polar, c, s); plane_rot(x, z, c, s);
        turn_sincos(azim, c, s);  plane_rot(x, y, c, -s);
      end
    endcase
    r.sat = 1'b0;
    r.x = clip32(x, r.sat);
    r.y = clip32(y, r.sat);
    r.z = clip32(z, r.sat);
    return r;
  endfunction

  // result monitor and random back pressure
  always @(posedge clk) begin
    rot_result_t e;
    n_cycle <= n_cycle + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_seen <= n_seen + 1;
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
                 out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.saturated);
        n_err <= n_err + 1;
      end else begin
        e = rotated_q.pop_front();
        if (e.sat) n_sat <= n_sat + 1;
        if (out_ch.out_x !== e.x || out_ch.out_y !== e.y ||
            out_ch.out_z !== e.z || out_ch.saturated !== e.sat) begin
          $display("%0t: mismatch exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                   $time, e.x, e.y, e.z, e.sat, out_ch.out_x, out_ch.out_y,
                   out_ch.out_z, out_ch.saturated);
          n_err <= n_err + 1;
        end
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= calm || ($urandom_range(99) >= 14);

  always @(posedge clk)
    if (n_cycle > 400000) begin
      $display("simulation failed");
      $finish;
    end

  // send one request; the expectation is queued at the accepting edge.
  // valid stays up on return so the next request can follow back to back.
  task automatic send_request(req_t op, logic [31:0] vx, vy, vz,
                              logic [15:0] a, b, cc, logic [31:0] rx, ry, rz);
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= op;
    in_ch.in_x <= vx; in_ch.in_y <= vy; in_ch.in_z <= vz;
    in_ch.angle_a <= a; in_ch.angle_b <= b; in_ch.angle_c <= cc;
    in_ch.ref_x <= rx; in_ch.ref_y <= ry; in_ch.ref_z <= rz;
    do @(posedge clk); while (!in_ch.ready);
    rotated_q.push_back(rotate_vector(op, vx, vy, vz, a, b, cc, rx, ry, rz));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (130) @(negedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.small_limit <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    limit_q = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(3);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      default: return $urandom_range(32'h1_0000) - 32'h8000 + ($urandom_range(1) ?
                        32'h0 : {{8{1'b0}}, 24'($urandom())});
    endcase
  endfunction

  task automatic test_directed();
    req_t ops [4] = '{REQ_EULER, REQ_ROT_Y, REQ_ROT_Z, REQ_ALIGN};
    foreach (ops[k]) begin
      send_request(ops[k], 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                   16'h4000, 16'h2000, 16'hC000, 32'h0001_0000, 32'h0, 32'h0);
      send_request(ops[k], 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   16'hFFFF, 16'h2000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000);
    end
    // zero reference, reference on the z axis, reference with |x| and |y| at the limit
    send_request(REQ_ALIGN, 32'h0001_0000, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                 32'h0, 32'h0, 32'h0);
    send_request(REQ_ALIGN, 32'h0001_0000, 32'h0001_0000, 32'h0, 16'h0, 16'h0,
                 16'h0, 32'h0, 32'h0, 32'hFFFF_0000);
    send_request(REQ_ALIGN, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h1, 32'h5);
    // zero vector and angle 0x8000
    send_request(REQ_EULER, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000,
                 32'h0, 32'h0, 32'h0);
    send_request(REQ_ROT_Z, 32'hFFFF_0000, 32'h0, 32'h0, 16'h8000, 16'h8000,
                 16'h8000, 32'h0, 32'h0, 32'h0);
    drain_pipe();
  endtask

  task automatic test_random(int count);
    logic [15:0] lim;
    for (int i = 0; i < count; i++) begin
      lim = limit_q;
      send_request(req_t'($urandom_range(3)), rand_comp(), rand_comp(), rand_comp(),
                   16'($urandom()), 16'($urandom()), 16'($urandom()),
                   $urandom_range(3) == 0 ? 32'($urandom_range(lim)) - (lim >> 1) :
                   rand_comp(),
                   $urandom_range(3) == 0 ? 32'($urandom_range(lim)) - (lim >> 1) :
                   rand_comp(),
                   rand_comp());
    end
    drain_pipe();
  endtask

  task automatic test_limit_sweep();
    logic [15:0] vals [4] = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0001};
    foreach (vals[k]) begin
      write_limit(vals[k]);
      test_random(250);
    end
  endtask

  task automatic test_burst();
    calm = 1'b1;
    test_random(300);
    calm = 1'b0;
  endtask

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.small_limit = '0;
    in_ch.valid = 1'b0; in_ch.req_type = '0;
    in_ch.in_x = '0; in_ch.in_y = '0; in_ch.in_z = '0;
    in_ch.angle_a = '0; in_ch.angle_b = '0; in_ch.angle_c = '0;
    in_ch.ref_x = '0; in_ch.ref_y = '0; in_ch.ref_z = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(500);
    test_limit_sweep();
    test_burst();
    $display("covered %0d requests in all four modes, %0d results, %0d saturated,",
             n_sent, n_seen, n_sat);
    $display("limit settings 0, 1, 256 and 65535, with random and no back pressure");
    if (n_err == 0 && rotated_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

`default_nettype wire
